// ----- rtl/hblm_pkg.sv -----
// hblm_pkg: shared types and constants of the heartbeat link-loss monitor.
// No dependencies.
package hblm_pkg;
  localparam int MaxPeers    = 16;
  localparam int MaxResults  = 16;
  localparam int AddrW       = 32;
  localparam int TimeW       = 32;
  localparam int PeriodW     = 24;
  localparam int LossW       = 8;
  localparam int SlackW      = 24;
  localparam int KindW       = 2;
  localparam int PaddrW      = 4;
  localparam int QueueDepth  = 2;
  localparam logic [TimeW-1:0] ThreshCap = 32'h7FFF_FFFF;

  localparam logic [KindW-1:0] KIND_RECORDED = 2'd0;
  localparam logic [KindW-1:0] KIND_DROPPED  = 2'd1;
  localparam logic [KindW-1:0] KIND_LOST     = 2'd2;

  localparam logic [PaddrW-1:0] REG_PERIOD = 4'h0;
  localparam logic [PaddrW-1:0] REG_LOSS   = 4'h4;
  localparam logic [PaddrW-1:0] REG_SLACK  = 4'h8;

  // command handed from the front to the back
  typedef struct packed {
    logic             is_scan;   // 1 scan table, 0 heartbeat
    logic [AddrW-1:0] addr;
    logic [TimeW-1:0] stamp;     // time_now after this command; a tick includes its own step
  } cmd_t;
endpackage

// ----- rtl/hblm_front.sv -----
// hblm_front: accepts input words, keeps time and the scan countdown, and
// pushes heartbeat/scan commands into a short queue. Uses hblm_pkg.
module hblm_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic [hblm_pkg::AddrW-1:0]    peer_addr,
  input  logic [hblm_pkg::PeriodW-1:0]  period_ticks,
  output hblm_pkg::cmd_t                q_data,
  output logic                          q_valid,
  input  logic                          q_pop
);
  localparam int Depth = hblm_pkg::QueueDepth;
  localparam int PtrW  = $clog2(Depth);

  hblm_pkg::cmd_t              q_mem [Depth];
  logic [PtrW-1:0]             wr_ptr, rd_ptr;
  logic [PtrW:0]               count;
  logic [hblm_pkg::TimeW-1:0]  time_now;
  logic [hblm_pkg::PeriodW-1:0] scan_countdown;
  logic [hblm_pkg::PeriodW-1:0] half;
  logic                        accept, push;
  hblm_pkg::cmd_t              cmd;

  assign in_ready = (count != (PtrW+1)'(Depth));
  assign accept   = in_valid && in_ready;
  assign half     = (period_ticks >> 1) == '0 ? hblm_pkg::PeriodW'(1) : (period_ticks >> 1);
  // a tick pushes only when it scans; heartbeats always push
  assign push     = accept && (!req_type || scan_countdown == '0);
  assign q_valid  = count != '0;
  assign q_data   = q_mem[rd_ptr];

  always_comb begin
    cmd.is_scan = req_type;
    cmd.addr    = peer_addr;
    cmd.stamp   = req_type ? time_now + 1'b1 : time_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now       <= '0;
      scan_countdown <= '0;
      wr_ptr         <= '0;
      rd_ptr         <= '0;
      count          <= '0;
    end else begin
      if (accept && req_type) begin
        time_now <= time_now + 1'b1;
        if (scan_countdown == '0) scan_countdown <= half - 1'b1;
        else                      scan_countdown <= scan_countdown - 1'b1;
      end
      if (push) begin
        q_mem[wr_ptr] <= cmd;
        wr_ptr        <= (wr_ptr == PtrW'(Depth-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) rd_ptr <= (rd_ptr == PtrW'(Depth-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (push ? 1'b1 : 1'b0) - (q_pop ? 1'b1 : 1'b0);
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == (PtrW+1)'(Depth) |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("queue underflow");
  a_time_step: assert property (@(posedge clk) disable iff (rst)
    accept && req_type |=> time_now == $past(time_now) + 1'b1) else $error("time step");
`endif
endmodule

// ----- rtl/hblm_back.sv -----
// hblm_back: owns the peer table and walks it one entry a cycle (pausing while a
// lost report waits on out_ready) for heartbeat lookups and loss scans. Uses hblm_pkg.
module hblm_back #(
  parameter int MAX_PEERS = hblm_pkg::MaxPeers
) (
  input  logic                          clk,
  input  logic                          rst,
  input  hblm_pkg::cmd_t                q_data,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  logic [hblm_pkg::PeriodW-1:0]  period_ticks,
  input  logic [hblm_pkg::LossW-1:0]    loss_count,
  input  logic [hblm_pkg::SlackW-1:0]   slack_ticks,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hblm_pkg::KindW-1:0]    kind,
  output logic [hblm_pkg::AddrW-1:0]    report_addr,
  output logic                          last
);
  localparam int IdxW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int CntW = $clog2(hblm_pkg::MaxResults + 1);

  typedef enum logic [2:0] {S_IDLE, S_THR, S_HB, S_SCAN, S_HOLD, S_OUT} state_t;
  state_t state;

  logic [MAX_PEERS-1:0]        valid_q;
  logic [hblm_pkg::AddrW-1:0]  addr_mem [MAX_PEERS];
  logic [hblm_pkg::TimeW-1:0]  seen_mem [MAX_PEERS];
  logic [IdxW-1:0]             idx, free_idx;
  logic                        free_found;
  logic [hblm_pkg::TimeW-1:0]  thr, elapsed;
  logic [hblm_pkg::TimeW+1:0]  prod;
  hblm_pkg::cmd_t              cur;
  logic                        at_end;
  // one pending lost report held until the next one or end of scan
  logic                        pend;
  logic [hblm_pkg::AddrW-1:0]  pend_addr;
  // lost peers taken so far in this scan; capped per scan
  logic [CntW-1:0]             n_lost;
  logic                        lost;

  assign at_end  = (idx == IdxW'(MAX_PEERS-1));
  assign elapsed = cur.stamp - seen_mem[idx];
  assign lost    = valid_q[idx] && (elapsed > thr) &&
                   (n_lost != CntW'(hblm_pkg::MaxResults));
  assign q_pop   = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid_q   <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur        <= q_data;
            idx        <= '0;
            free_found <= 1'b0;
            pend       <= 1'b0;
            n_lost     <= '0;
            prod       <= 34'(32'(loss_count) * 32'(period_ticks)) + 34'(slack_ticks);
            state      <= q_data.is_scan ? S_THR : S_HB;
          end
        end
        S_THR: begin
          thr   <= (prod > 34'(hblm_pkg::ThreshCap)) ? hblm_pkg::ThreshCap
                                                     : prod[hblm_pkg::TimeW-1:0];
          state <= S_SCAN;
        end
        S_HB: begin
          if (valid_q[idx] && addr_mem[idx] == cur.addr) begin
            seen_mem[idx] <= cur.stamp;
            kind <= hblm_pkg::KIND_RECORDED; report_addr <= cur.addr; last <= 1'b1;
            out_valid <= 1'b1; state <= S_OUT;
          end else begin
            if (!valid_q[idx] && !free_found) begin
              free_found <= 1'b1; free_idx <= idx;
            end
            if (at_end) begin
              if (free_found || !valid_q[idx]) begin
                valid_q[free_found ? free_idx : idx]  <= 1'b1;
                addr_mem[free_found ? free_idx : idx] <= cur.addr;
                seen_mem[free_found ? free_idx : idx] <= cur.stamp;
                kind <= hblm_pkg::KIND_RECORDED;
              end else begin
                kind <= hblm_pkg::KIND_DROPPED;
              end
              report_addr <= cur.addr; last <= 1'b1;
              out_valid <= 1'b1; state <= S_OUT;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (lost) begin
            valid_q[idx] <= 1'b0;
            n_lost       <= n_lost + 1'b1;
          end
          if (lost && pend) begin
            // earlier report goes out, this entry becomes the pending one
            kind <= hblm_pkg::KIND_LOST; report_addr <= pend_addr; last <= 1'b0;
            out_valid <= 1'b1; pend_addr <= addr_mem[idx]; state <= S_HOLD;
          end else if (at_end) begin
            if (pend || lost) begin
              kind <= hblm_pkg::KIND_LOST; last <= 1'b1; out_valid <= 1'b1;
              report_addr <= pend ? pend_addr : addr_mem[idx];
              pend <= 1'b0; state <= S_OUT;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            if (lost) begin
              pend <= 1'b1; pend_addr <= addr_mem[idx];
            end
            idx <= idx + 1'b1;
          end
        end
        S_HOLD: begin
          if (out_ready) begin
            if (at_end) begin
              kind <= hblm_pkg::KIND_LOST; report_addr <= pend_addr; last <= 1'b1;
              pend <= 1'b0; state <= S_OUT;
            end else begin
              out_valid <= 1'b0; idx <= idx + 1'b1; state <= S_SCAN;
            end
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_out_in_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_OUT || state == S_HOLD)) else $error("stray output");
  a_hold_kind: assert property (@(posedge clk) disable iff (rst)
    state == S_HOLD |-> kind == hblm_pkg::KIND_LOST && !last) else $error("hold kind");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state != S_IDLE) else $error("pop without work");
`endif
endmodule

// ----- rtl/heartbeat_link_loss_monitor_top.sv -----
// heartbeat_link_loss_monitor_top: top level with APB register file.
// Depends on hblm_pkg, hblm_front, hblm_back.
//
// channel  | handshake             | payload
// in       | in_valid / in_ready   | req_type, peer_addr
// out      | out_valid / out_ready | kind, report_addr, last
// cfg      | psel/penable/pwrite   | paddr, pwdata, prdata
//
// Front takes a word a cycle while its 2-entry queue has room; ticks that
// do not scan never reach the back. The back walks the table one entry per
// cycle while no lost report waits on out_ready, and takes the next command
// only when done; a heartbeat stops at a matching entry, a scan visits all.
// Each result waits in the output register until out_ready.
// rst is synchronous, active high; it clears the table valid bits and time.
module heartbeat_link_loss_monitor_top #(
  parameter int MAX_PEERS = hblm_pkg::MaxPeers
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              req_type,
  input  logic [hblm_pkg::AddrW-1:0]        peer_addr,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [hblm_pkg::KindW-1:0]        kind,
  output logic [hblm_pkg::AddrW-1:0]        report_addr,
  output logic                              last,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hblm_pkg::PaddrW-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  logic [hblm_pkg::PeriodW-1:0] period_ticks;
  logic [hblm_pkg::LossW-1:0]   loss_count;
  logic [hblm_pkg::SlackW-1:0]  slack_ticks;
  hblm_pkg::cmd_t               q_data;
  logic                         q_valid, q_pop;

  assign pready = 1'b1;

  // register writes on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      period_ticks <= hblm_pkg::PeriodW'(1000);
      loss_count   <= hblm_pkg::LossW'(3);
      slack_ticks  <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        hblm_pkg::REG_PERIOD: period_ticks <= pwdata[hblm_pkg::PeriodW-1:0];
        hblm_pkg::REG_LOSS:   loss_count   <= pwdata[hblm_pkg::LossW-1:0];
        hblm_pkg::REG_SLACK:  slack_ticks  <= pwdata[hblm_pkg::SlackW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      hblm_pkg::REG_PERIOD: prdata = 32'(period_ticks);
      hblm_pkg::REG_LOSS:   prdata = 32'(loss_count);
      hblm_pkg::REG_SLACK:  prdata = 32'(slack_ticks);
      default:              prdata = '0;
    endcase
  end

  hblm_front u_front (
    .clk, .rst, .in_valid, .in_ready, .req_type, .peer_addr, .period_ticks,
    .q_data, .q_valid, .q_pop
  );

  hblm_back #(.MAX_PEERS(MAX_PEERS)) u_back (
    .clk, .rst, .q_data, .q_valid, .q_pop, .period_ticks, .loss_count,
    .slack_ticks, .out_valid, .out_ready, .kind, .report_addr, .last
  );
endmodule

// ----- verif/heartbeat_link_loss_monitor_top_test.sv -----
// Testbench for heartbeat_link_loss_monitor_top: heartbeat and tick words are
// driven against an in-bench table predictor; every result word is compared in order.
// Depends on hblm_pkg and the RTL of heartbeat_link_loss_monitor_top.
module heartbeat_link_loss_monitor_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPeers = hblm_pkg::MaxPeers;
  localparam logic REQ_HEARTBEAT = 1'b0;
  localparam logic REQ_TICK      = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = 1'b0;
  logic [hblm_pkg::AddrW-1:0] peer_addr = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [hblm_pkg::KindW-1:0] kind;
  logic [hblm_pkg::AddrW-1:0] report_addr;
  logic last;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [hblm_pkg::PaddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  heartbeat_link_loss_monitor_top dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // One expected result word.
  typedef struct packed {
    logic [hblm_pkg::KindW-1:0] kind;
    logic [hblm_pkg::AddrW-1:0] addr;
    logic                       last;
  } report_t;

  report_t pending_reports[$];
  int errors = 0;

  // Predictor copy of the register file and peer table.
  logic [hblm_pkg::PeriodW-1:0] m_period = 24'd1000;
  logic [hblm_pkg::LossW-1:0]   m_loss = 8'd3;
  logic [hblm_pkg::SlackW-1:0]  m_slack = '0;
  logic                         t_valid[NPeers];
  logic [hblm_pkg::AddrW-1:0]   t_addr[NPeers];
  logic [hblm_pkg::TimeW-1:0]   t_seen[NPeers];
  logic [hblm_pkg::TimeW-1:0]   now_ticks = '0;
  logic [hblm_pkg::PeriodW-1:0] countdown = '0;

  // Stall rates in percent; changed per phase.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;

  function automatic void expect_report(logic [hblm_pkg::KindW-1:0] k,
                                        logic [hblm_pkg::AddrW-1:0] a, logic l);
    report_t r;
    r.kind = k;
    r.addr = a;
    r.last = l;
    pending_reports.insert(pending_reports.size(), r);
  endfunction

  function automatic logic [hblm_pkg::TimeW-1:0] loss_limit();
    logic [63:0] t;
    t = 64'(m_loss) * 64'(m_period) + 64'(m_slack);
    if (t > 64'(hblm_pkg::ThreshCap)) t = 64'(hblm_pkg::ThreshCap);
    return t[hblm_pkg::TimeW-1:0];
  endfunction

  // Heartbeat: refresh known peer, else take lowest free entry, else drop.
  function automatic void predict_heartbeat(logic [hblm_pkg::AddrW-1:0] a);
    int free_idx;
    free_idx = -1;
    for (int i = 0; i < NPeers; i++) begin
      if (t_valid[i]) begin
        if (t_addr[i] == a) begin
          t_seen[i] = now_ticks;
          expect_report(hblm_pkg::KIND_RECORDED, a, 1'b1);
          return;
        end
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (free_idx < 0) begin
      expect_report(hblm_pkg::KIND_DROPPED, a, 1'b1);
      return;
    end
    t_valid[free_idx] = 1'b1;
    t_addr[free_idx] = a;
    t_seen[free_idx] = now_ticks;
    expect_report(hblm_pkg::KIND_RECORDED, a, 1'b1);
  endfunction

  // Tick: advance time, scan on countdown zero; reports per scan are capped.
  function automatic void predict_tick();
    logic [hblm_pkg::TimeW-1:0] thr;
    logic [hblm_pkg::PeriodW-1:0] half;
    int n;
    now_ticks = now_ticks + 1;
    if (countdown != 0) begin
      countdown = countdown - 1;
      return;
    end
    half = m_period >> 1;
    if (half == 0) half = 1;
    countdown = half - 1;
    thr = loss_limit();
    n = 0;
    for (int i = 0; i < NPeers && n < hblm_pkg::MaxResults; i++) begin
      if (t_valid[i] && (now_ticks - t_seen[i]) > thr) begin
        t_valid[i] = 1'b0;
        expect_report(hblm_pkg::KIND_LOST, t_addr[i], 1'b0);
        n++;
      end
    end
    if (n > 0) pending_reports[$].last = 1'b1;
  endfunction

  // Offer one word, hold until accepted, update the predictor. Valid stays
  // up for a following word; idle cycles and drain() take it down.
  task automatic send_word(logic rt, logic [hblm_pkg::AddrW-1:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    peer_addr <= a;
    do @(posedge clk); while (!in_ready);
    if (rt == REQ_HEARTBEAT) predict_heartbeat(a);
    else predict_tick();
    @(negedge clk);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_word(REQ_TICK, $urandom);
  endtask

  // Stop offering, wait for all expected words, then let scans with no
  // result drain.
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_reports.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (60) @(negedge clk);
  endtask

  task automatic apb_write(logic [hblm_pkg::PaddrW-1:0] a, logic [31:0] d);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= d; penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (a == hblm_pkg::REG_PERIOD) m_period = d[hblm_pkg::PeriodW-1:0];
    else if (a == hblm_pkg::REG_LOSS) m_loss = d[hblm_pkg::LossW-1:0];
    else if (a == hblm_pkg::REG_SLACK) m_slack = d[hblm_pkg::SlackW-1:0];
    @(negedge clk);
  endtask

  task automatic set_regs(logic [31:0] per, logic [31:0] loss, logic [31:0] slk);
    drain();
    apb_write(hblm_pkg::REG_PERIOD, per);
    apb_write(hblm_pkg::REG_LOSS, loss);
    apb_write(hblm_pkg::REG_SLACK, slk);
  endtask

  // Receiver: random ready, or held low while recv_hold is set.
  always @(negedge clk) begin
    if (!rst) out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker.
  always @(posedge clk) begin
    report_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("result word with nothing expected: kind %0d addr %h", kind, report_addr);
        errors++;
      end else begin
        exp_r = pending_reports.pop_front();
        if (kind !== exp_r.kind) begin
          $error("kind: expected %0d actual %0d", exp_r.kind, kind); errors++;
        end
        if (report_addr !== exp_r.addr) begin
          $error("report_addr: expected %h actual %h", exp_r.addr, report_addr); errors++;
        end
        if (last !== exp_r.last) begin
          $error("last: expected %0d actual %0d", exp_r.last, last); errors++;
        end
      end
    end
  end

  // Directed: address extremes, refresh, full table, drop, loss with
  // small period, register extremes.
  task automatic test_directed();
    send_word(REQ_HEARTBEAT, 32'h0000_0000);
    send_word(REQ_HEARTBEAT, 32'hFFFF_FFFF);
    send_word(REQ_HEARTBEAT, 32'h0000_0000);       // known peer refresh
    for (int i = 0; i < 14; i++) send_word(REQ_HEARTBEAT, 32'hA5A5_0000 + i);
    send_word(REQ_HEARTBEAT, 32'h5A5A_5A5A);       // full table: dropped
    set_regs(32'd0, 32'd1, 32'd0);                 // small period, scan every tick
    send_ticks(3);                                 // whole table lost in one scan
    set_regs(32'd1, 32'd255, 32'hFF_FFFF);
    send_word(REQ_HEARTBEAT, 32'h1234_5678);
    send_ticks(2);
  endtask

  // Random: heartbeats, mostly from a small address pool, and ticks (the majority) to age them.
  task automatic test_random(int n);
    logic [hblm_pkg::AddrW-1:0] a;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 45) begin
        a = ($urandom_range(3) == 0) ? $urandom : 32'hC0A8_0000 + $urandom_range(19);
        send_word(REQ_HEARTBEAT, a);
      end else begin
        send_word(REQ_TICK, $urandom);
      end
    end
  endtask

  // Receiver stalled for a long stretch while words keep coming.
  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1'b1;
        repeat (400) @(negedge clk);
        recv_hold = 1'b0;
      end
      test_random(30);
    join
    drain();   // sender pause until every result is in
  endtask

  initial begin
    for (int i = 0; i < NPeers; i++) begin
      t_valid[i] = 1'b0; t_addr[i] = '0; t_seen[i] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 21; recv_idle_pct = 86;
    test_directed();
    set_regs(32'd6, 32'd2, 32'd3);
    test_random(160);
    send_idle_pct = 86; recv_idle_pct = 21;
    set_regs(32'd4, 32'd1, 32'd0);
    test_random(140);
    send_idle_pct = 0; recv_idle_pct = 0;
    set_regs(32'd2, 32'd3, 32'd1);
    test_random(120);
    set_regs(32'hFF_FFFF, 32'd255, 32'hFF_FFFF);   // saturated threshold
    test_random(20);
    set_regs(32'd3, 32'd1, 32'd0);
    test_backpressure();

    drain();
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end
endmodule

// ----- heartbeat_link_loss_monitor_top.f -----
rtl/hblm_pkg.sv
rtl/hblm_front.sv
rtl/hblm_back.sv
rtl/heartbeat_link_loss_monitor_top.sv
verif/heartbeat_link_loss_monitor_top_test.sv
